// File: rtl/tced_pkg.sv
// Shared types for the termcap escape decoder.
// Holds the result item and the per-byte decode bundle; no dependencies.
package tced_pkg;

	// One decoded result as it travels to the output queue.
	typedef struct packed {
		logic [7:0] data;
		logic       end_mark;
	} res_t;

	// Everything one input byte produces: zero, one or two results.
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} dec_t;

	localparam logic [7:0] END_CODE = 8'h00;

endpackage

// File: rtl/termcap_escape_decoder.sv
// Top level of the termcap escape decoder: input register, parser, result queue.
// Depends on tced_pkg and tced_decode.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------
//   input   | in_valid  | in_stall  | in_byte
//   output  | out_valid | out_stall | out_byte, end_mark
//
// One byte request is taken per cycle while in_stall is low. An accepted byte is held in the
// input register while the parser decodes it, and its results are written into the result
// queue when it retires; out_valid comes from the registered queue count. The queue takes up
// to two results per cycle and drains one per cycle while out_stall is low; a byte whose
// results do not fit beside the registered queue count holds the input register and raises
// in_stall. Reset clears the parser state, the input valid flag and the queue pointers.
module termcap_escape_decoder #(
	// Result queue depth; a power of two, at least 4.
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       end_mark
);
	import tced_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result queue, written at one or two slots and read at the head.
	res_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	dec_t             dec;
	logic             step;
	logic             accept_in;
	logic             pop;
	logic [PTR_W-1:0] wr_ptr_next;
	res_t             head;

	tced_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.cur_byte (byte_s1),
		.dec      (dec)
	);

	// The held byte retires only when the queue has room for all of its results.
	// The room check looks at the registered count, so there is no combinational
	// path from out_stall to in_stall.
	assign step = valid_s1 &&
		((CNT_W + 1)'(count_q) + (CNT_W + 1)'(dec.count) <= (CNT_W + 1)'(FIFO_DEPTH));

	assign in_stall  = valid_s1 && !step;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_s1 <= in_byte;
		end
	end

	assign pop         = out_valid && !out_stall;
	assign wr_ptr_next = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (step && dec.count != 2'd0) begin
			mem_q[wr_ptr_q] <= dec.r0;
		end
		if (step && dec.count == 2'd2) begin
			mem_q[wr_ptr_next] <= dec.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (step) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(dec.count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + (step ? CNT_W'(dec.count) : CNT_W'(0)) -
				(pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign out_valid = (count_q != '0);
	assign out_byte  = head.data;
	assign end_mark  = head.end_mark;

endmodule

// File: rtl/tced_decode.sv
// Escape parser: mode, octal value and digit count, plus the decode of one byte.
// Depends on tced_pkg for the result types.
module tced_decode (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    cur_byte,
	output tced_pkg::dec_t dec
);
	import tced_pkg::*;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_BSLASH,
		MODE_CARET,
		MODE_OCTAL
	} mode_t;

	localparam logic [7:0] CHR_BSLASH = 8'h5C;
	localparam logic [7:0] CHR_CARET  = 8'h5E;
	localparam logic [7:0] CHR_UPPER_E = 8'h45;
	localparam logic [7:0] CHR_LOWER_E = 8'h65;
	localparam logic [7:0] CHR_N      = 8'h6E;
	localparam logic [7:0] CHR_R      = 8'h72;
	localparam logic [7:0] CHR_T      = 8'h74;
	localparam logic [7:0] CHR_B      = 8'h62;
	localparam logic [7:0] CHR_F      = 8'h66;
	localparam logic [7:0] ESC_CODE   = 8'h1B;
	localparam logic [7:0] LF_CODE    = 8'h0A;
	localparam logic [7:0] CR_CODE    = 8'h0D;
	localparam logic [7:0] TAB_CODE   = 8'h09;
	localparam logic [7:0] BS_CODE    = 8'h08;
	localparam logic [7:0] FF_CODE    = 8'h0C;
	localparam logic [7:0] CTRL_MASK  = 8'h1F;
	localparam logic [4:0] OCT_PREFIX = 5'b00110;
	localparam logic [1:0] LAST_DIGIT = 2'd3;

	mode_t      mode_q, mode_d;
	logic [7:0] oval_q, oval_d;
	logic [1:0] odig_q, odig_d;

	logic       is_oct;
	logic [7:0] oval_shift;
	logic [1:0] odig_inc;
	logic       norm_emit;
	res_t       norm_res;
	mode_t      norm_mode;
	logic [7:0] esc_byte;

	assign is_oct     = (cur_byte[7:3] == OCT_PREFIX);
	assign oval_shift = {oval_q[4:0], cur_byte[2:0]};
	assign odig_inc   = odig_q + 2'd1;

	// Plain-text handling, also used for the byte that cuts an octal run short.
	always_comb begin
		norm_emit = 1'b0;
		norm_res  = '{data: cur_byte, end_mark: 1'b0};
		norm_mode = MODE_NORMAL;
		if (cur_byte == END_CODE) begin
			norm_emit = 1'b1;
			norm_res  = '{data: END_CODE, end_mark: 1'b1};
		end else if (cur_byte == CHR_BSLASH) begin
			norm_mode = MODE_BSLASH;
		end else if (cur_byte == CHR_CARET) begin
			norm_mode = MODE_CARET;
		end else begin
			norm_emit = 1'b1;
		end
	end

	always_comb begin
		case (cur_byte)
			CHR_UPPER_E, CHR_LOWER_E: esc_byte = ESC_CODE;
			CHR_N:                    esc_byte = LF_CODE;
			CHR_R:                    esc_byte = CR_CODE;
			CHR_T:                    esc_byte = TAB_CODE;
			CHR_B:                    esc_byte = BS_CODE;
			CHR_F:                    esc_byte = FF_CODE;
			default:                  esc_byte = cur_byte;
		endcase
	end

	always_comb begin
		mode_d    = mode_q;
		oval_d    = oval_q;
		odig_d    = odig_q;
		dec.count = 2'd0;
		dec.r0    = '{data: END_CODE, end_mark: 1'b1};
		dec.r1    = '{data: END_CODE, end_mark: 1'b1};
		case (mode_q)
			MODE_BSLASH: begin
				mode_d = MODE_NORMAL;
				if (cur_byte == END_CODE) begin
					dec.count = 2'd1;
				end else if (is_oct) begin
					mode_d = MODE_OCTAL;
					oval_d = {5'd0, cur_byte[2:0]};
					odig_d = 2'd1;
				end else begin
					dec.count = 2'd1;
					dec.r0    = '{data: esc_byte, end_mark: 1'b0};
				end
			end
			MODE_CARET: begin
				mode_d    = MODE_NORMAL;
				dec.count = 2'd1;
				if (cur_byte != END_CODE) begin
					dec.r0 = '{data: cur_byte & CTRL_MASK, end_mark: 1'b0};
				end
			end
			MODE_OCTAL: begin
				if (is_oct) begin
					if (odig_inc == LAST_DIGIT) begin
						dec.count = 2'd1;
						dec.r0    = '{data: oval_shift, end_mark: 1'b0};
						mode_d    = MODE_NORMAL;
						oval_d    = 8'd0;
						odig_d    = 2'd0;
					end else begin
						oval_d = oval_shift;
						odig_d = odig_inc;
					end
				end else begin
					// The run is cut short: emit the value, then treat the byte as text.
					dec.count = norm_emit ? 2'd2 : 2'd1;
					dec.r0    = '{data: oval_q, end_mark: 1'b0};
					dec.r1    = norm_res;
					mode_d    = norm_mode;
					oval_d    = 8'd0;
					odig_d    = 2'd0;
				end
			end
			default: begin
				mode_d    = norm_mode;
				dec.count = norm_emit ? 2'd1 : 2'd0;
				dec.r0    = norm_res;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			oval_q <= 8'd0;
			odig_q <= 2'd0;
		end else if (step) begin
			mode_q <= mode_d;
			oval_q <= oval_d;
			odig_q <= odig_d;
		end
	end

endmodule

// File: rtl/tced_checker.sv
// Port-level checks for the termcap escape decoder, bound to its top level.
// Depends only on the top level's ports.
module tced_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       end_mark
);

	// The end marker always carries a zero byte.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_mark |-> out_byte == 8'h00)
		else $error("end marker with nonzero byte");

	// A result never appears out of an empty queue without an earlier accepted byte.
	a_rise_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without an accepted request");

	// Input is held back only while the result queue is backed up.
	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty result queue");

	// A stalled result stays offered and unchanged.
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(end_mark))
		else $error("result withdrawn or changed while stalled");

	// A stalled byte request stays offered and unchanged.
	a_in_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte))
		else $error("byte request withdrawn or changed while stalled");

endmodule

bind termcap_escape_decoder tced_checker u_tced_checker (.*);

// File: sim/termcap_escape_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for termcap_escape_decoder: a directed table, then random escape strings.
// Depends on tced_pkg for the result types and on the decoder RTL itself.
module termcap_escape_decoder_tb;
	import tced_pkg::*;

	// Characters with a meaning to the decoder.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] ESC_CHAR  = 8'h1B;
	localparam logic [7:0] CTRL_MASK = 8'h1F;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 200;
	localparam int DRAIN_LIMIT = 5000;
	localparam int PRINT_CAP   = 40;

	typedef enum logic [1:0] {
		SCAN_PLAIN,
		SCAN_BSLASH,
		SCAN_CARET,
		SCAN_OCTAL
	} scan_mode_t;

	// One row of the directed table. Rows with want_typed set carry the
	// decoded character written out by hand; the others use the predictor.
	typedef struct {
		logic [7:0] ch;
		bit         want_typed;
		logic [7:0] want_data;
		logic       want_end;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       end_mark;

	// Predictor state, mirroring the parser of the block.
	scan_mode_t scan_mode;
	logic [7:0] oct_acc;
	logic [1:0] oct_count;

	res_t expected_chars [$];

	int idle_pct;
	int stall_pct;
	bit hold_pending;
	int cycle_count;
	int bytes_sent;
	int chars_checked;
	int mismatch_count;

	row_t directed_rows [27] = '{
		// Plain extreme and the end of a string right after reset.
		'{8'hFF, 1'b1, 8'hFF, 1'b0},
		'{END_CODE, 1'b1, END_CODE, 1'b1},
		// Named escapes.
		'{CH_BSLASH, 1'b0, 8'h00, 1'b0},
		'{"E", 1'b1, ESC_CHAR, 1'b0},
		'{CH_BSLASH, 1'b0, 8'h00, 1'b0},
		'{CH_CARET, 1'b1, CH_CARET, 1'b0},
		'{CH_BSLASH, 1'b0, 8'h00, 1'b0},
		'{CH_BSLASH, 1'b1, CH_BSLASH, 1'b0},
		// A full three digit octal run, the largest value.
		'{CH_BSLASH, 1'b0, 8'h00, 1'b0},
		'{"3", 1'b0, 8'h00, 1'b0},
		'{"7", 1'b0, 8'h00, 1'b0},
		'{"7", 1'b1, 8'hFF, 1'b0},
		// An octal run cut short by the end byte gives two results.
		'{CH_BSLASH, 1'b0, 8'h00, 1'b0},
		'{"7", 1'b0, 8'h00, 1'b0},
		'{END_CODE, 1'b0, 8'h00, 1'b0},
		// Caret at sign decodes to a data zero, not an end marker.
		'{CH_CARET, 1'b0, 8'h00, 1'b0},
		'{"@", 1'b1, 8'h00, 1'b0},
		'{CH_CARET, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b1, CTRL_MASK, 1'b0},
		// Dangling backslash and dangling caret before the end byte.
		'{CH_BSLASH, 1'b0, 8'h00, 1'b0},
		'{END_CODE, 1'b1, END_CODE, 1'b1},
		'{CH_CARET, 1'b0, 8'h00, 1'b0},
		'{END_CODE, 1'b1, END_CODE, 1'b1},
		// An octal run cut short by a letter, which then passes through.
		'{CH_BSLASH, 1'b0, 8'h00, 1'b0},
		'{"1", 1'b0, 8'h00, 1'b0},
		'{"2", 1'b0, 8'h00, 1'b0},
		'{"Z", 1'b0, 8'h00, 1'b0}
	};

	termcap_escape_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.end_mark  (end_mark)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("[%0t] decode error: %s", $realtime, what);
		end
	endtask

	// Appends one decoded character to the results of the current byte.
	function automatic dec_t add_char(dec_t d, logic [7:0] data, logic fin);
		res_t r;
		r.data = data;
		r.end_mark = fin;
		if (d.count == 2'd0) begin
			d.r0 = r;
		end else begin
			d.r1 = r;
		end
		d.count = d.count + 2'd1;
		return d;
	endfunction

	// A byte seen in plain mode: end, escape prefix, caret prefix or itself.
	function automatic dec_t plain_char(dec_t d, logic [7:0] b);
		scan_mode = SCAN_PLAIN;
		if (b == END_CODE) begin
			d = add_char(d, END_CODE, 1'b1);
		end else if (b == CH_BSLASH) begin
			scan_mode = SCAN_BSLASH;
		end else if (b == CH_CARET) begin
			scan_mode = SCAN_CARET;
		end else begin
			d = add_char(d, b, 1'b0);
		end
		return d;
	endfunction

	// Works out what one accepted byte decodes to and advances the parser state.
	function automatic dec_t decode_char(logic [7:0] b);
		dec_t d;
		logic is_digit;
		d = '0;
		is_digit = (b >= CH_ZERO) && (b <= CH_SEVEN);
		case (scan_mode)
			SCAN_BSLASH: begin
				scan_mode = SCAN_PLAIN;
				if (b == END_CODE) begin
					d = add_char(d, END_CODE, 1'b1);
				end else if (is_digit) begin
					oct_acc = {5'd0, b[2:0]};
					oct_count = 2'd1;
					scan_mode = SCAN_OCTAL;
				end else begin
					case (b)
						"E", "e": d = add_char(d, ESC_CHAR, 1'b0);
						"n":      d = add_char(d, 8'h0A, 1'b0);
						"r":      d = add_char(d, 8'h0D, 1'b0);
						"t":      d = add_char(d, 8'h09, 1'b0);
						"b":      d = add_char(d, 8'h08, 1'b0);
						"f":      d = add_char(d, 8'h0C, 1'b0);
						default:  d = add_char(d, b, 1'b0);
					endcase
				end
			end
			SCAN_CARET: begin
				scan_mode = SCAN_PLAIN;
				if (b == END_CODE) begin
					d = add_char(d, END_CODE, 1'b1);
				end else begin
					d = add_char(d, b & CTRL_MASK, 1'b0);
				end
			end
			SCAN_OCTAL: begin
				if (is_digit) begin
					// Only the low eight bits of the value are kept.
					oct_acc = {oct_acc[4:0], b[2:0]};
					oct_count = oct_count + 2'd1;
					if (oct_count == 2'd3) begin
						d = add_char(d, oct_acc, 1'b0);
						scan_mode = SCAN_PLAIN;
						oct_acc = '0;
						oct_count = '0;
					end
				end else begin
					// The run ends early: emit the value, then treat the byte as plain.
					d = add_char(d, oct_acc, 1'b0);
					oct_acc = '0;
					oct_count = '0;
					d = plain_char(d, b);
				end
			end
			default: begin
				d = plain_char(d, b);
			end
		endcase
		return d;
	endfunction

	// Offers one byte request, holding it steady while the block stalls, and
	// records what it decodes to once it is taken. A typed row replaces the
	// predicted character with the one written in the table.
	task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
			input res_t typed_res = '0);
		dec_t d;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		d = decode_char(b);
		if (typed) begin
			expected_chars.push_back(typed_res);
		end else begin
			if (d.count > 2'd0) begin
				expected_chars.push_back(d.r0);
			end
			if (d.count > 2'd1) begin
				expected_chars.push_back(d.r1);
			end
		end
		bytes_sent++;
	endtask

	// One random piece of an escaped string: a plain character, a well formed
	// escape with random content, an end byte, or raw noise over the full byte range.
	task automatic send_token();
		int pick;
		int digits;
		int digit;
		logic [7:0] ch;
		pick = $urandom_range(99);
		if (pick < 30) begin
			ch = 8'($urandom_range(255, 1));
			if (ch == CH_BSLASH || ch == CH_CARET) begin
				ch = "a";
			end
			send_byte(ch);
		end else if (pick < 50) begin
			send_byte(CH_BSLASH);
			case ($urandom_range(9))
				0: ch = "E";
				1: ch = "e";
				2: ch = "n";
				3: ch = "r";
				4: ch = "t";
				5: ch = "b";
				6: ch = "f";
				7: ch = CH_CARET;
				8: ch = CH_BSLASH;
				default: ch = 8'($urandom_range(255));
			endcase
			send_byte(ch);
		end else if (pick < 65) begin
			send_byte(CH_BSLASH);
			digits = $urandom_range(3, 1);
			repeat (digits) begin
				digit = $urandom_range(7);
				send_byte(CH_ZERO + digit[7:0]);
			end
			// Now and then a short run is cut off by the end of the string.
			if (digits < 3 && $urandom_range(2) == 0) begin
				send_byte(END_CODE);
			end
		end else if (pick < 75) begin
			send_byte(CH_CARET);
			send_byte(8'($urandom_range(255)));
		end else if (pick < 85) begin
			send_byte(END_CODE);
		end else begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	// Receiver: random stalls at the phase's rate, or a long hold-off on request
	// so that the result queue fills and the block backs up into the sender.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Every character taken from the block is checked against the oldest
	// expectation. Results pass through the input register and the result queue, so the
	// entry pushed by the sender at the same edge is never the one needed here.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				flag_mismatch($sformatf("unexpected character %02h end %0b", out_byte, end_mark));
			end else begin
				want = expected_chars.pop_front();
				if (out_byte !== want.data) begin
					flag_mismatch($sformatf("character %0d: out_byte %02h, want %02h",
						chars_checked, out_byte, want.data));
				end
				if (end_mark !== want.end_mark) begin
					flag_mismatch($sformatf("character %0d: end_mark %0b, want %0b",
						chars_checked, end_mark, want.end_mark));
				end
				chars_checked++;
			end
		end
	end

	// Watchdog: a correct run ends far below this.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("Mismatches found");
		$finish;
	end

	initial begin : main_seq
		int drain;
		int phase;
		res_t typed_res;
		idle_pct = 0;
		stall_pct = 0;
		hold_pending = 1'b0;
		bytes_sent = 0;
		chars_checked = 0;
		mismatch_count = 0;
		scan_mode = SCAN_PLAIN;
		oct_acc = '0;
		oct_count = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table, no idling on either side.
		foreach (directed_rows[i]) begin
			typed_res.data = directed_rows[i].want_data;
			typed_res.end_mark = directed_rows[i].want_end;
			send_byte(directed_rows[i].ch, directed_rows[i].want_typed, typed_res);
		end

		// Long receiver hold-off while the sender keeps offering bytes.
		hold_pending = 1'b1;
		while (bytes_sent < 90) begin
			send_token();
		end

		// Random strings in four idling phases: none, sender idle, receiver
		// stalling, and both together.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 75; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 75; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			while (bytes_sent < 90 + (phase + 1) * 460) begin
				send_token();
			end
		end
		in_valid <= 1'b0;

		drain = 0;
		while (expected_chars.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		// Waiting on after the drain catches any stray character the block still emits.
		repeat (10) @(posedge clk);
		if (expected_chars.size() != 0) begin
			flag_mismatch($sformatf("%0d expected characters never arrived",
				expected_chars.size()));
		end

		$display("Sent %0d bytes and checked %0d decoded characters in %0d cycles,",
			bytes_sent, chars_checked, cycle_count);
		$display("covering every escape form, a long output hold-off and four idling mixes.");
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
